>>> hdl/assert_macros.svh
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hdl/asc_pkg.sv
// types and constants of the aging slot cache
package asc_pkg;

	localparam int IDX_W   = 5;
	localparam int ID_W    = 16;
	localparam int SCORE_W = 16;
	localparam int FRM_W   = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MASK_W  = 32;

	typedef logic [IDX_W-1:0] slot_idx_t;

	localparam logic [CFG_IDX_W-1:0] REG_SCORE_ON_USE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCAN_START   = 2'd1;

	typedef enum logic [2:0] {
		ST_HIT         = 3'd0,
		ST_LOADED      = 3'd1,
		ST_EVICTED     = 3'd2,
		ST_BUSY        = 3'd3,
		ST_LOAD_FAIL   = 3'd4,
		ST_UNLOCKED    = 3'd5,
		ST_RELOAD_FAIL = 3'd6,
		ST_TICK_DONE   = 3'd7
	} status_t;

	// search record handed from cell to cell
	typedef struct packed {
		logic                act;
		logic                hit;
		slot_idx_t           hit_idx;
		logic                free;
		slot_idx_t           free_idx;
		logic [SCORE_W-1:0]  best;
		slot_idx_t           victim;
	} scan_rec_t;

	// command broadcast from the controller to all cells
	typedef struct packed {
		logic                tick;
		logic [FRM_W-1:0]    frames;
		logic                we;
		slot_idx_t           idx;
		logic                valid_val;
		logic                id_en;
		logic                score_en;
		logic [ID_W-1:0]     id;
		logic [SCORE_W-1:0]  score;
	} slot_cmd_t;

endpackage

>>> hdl/asc_cell.sv
// one slot of the cache: state, aging and one step of the search chain
module asc_cell import asc_pkg::*; #(
	parameter int INDEX = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  slot_cmd_t cmd,
	input  scan_rec_t rec_in,
	output scan_rec_t rec_out,
	output logic      freed
);

	localparam slot_idx_t MY_IDX = slot_idx_t'(INDEX);

	logic                valid_q;
	logic [ID_W-1:0]     id_q;
	logic [SCORE_W-1:0]  score_q;
	scan_rec_t           rec_q;
	scan_rec_t           rec_nxt;
	logic [SCORE_W:0]    aged;
	logic                nonpos;
	logic                my_wr;

	// full precision difference so it cannot wrap
	assign aged   = {score_q[SCORE_W-1], score_q} - {{(SCORE_W+1-FRM_W){1'b0}}, cmd.frames};
	assign nonpos = aged[SCORE_W] || (aged == '0);
	assign freed  = cmd.tick && (id_q != '0) && nonpos;
	assign my_wr  = cmd.we && (cmd.idx == MY_IDX);

	always_comb begin
		rec_nxt = rec_in;
		if (!rec_in.hit && valid_q && (id_q == cmd.id)) begin
			rec_nxt.hit     = 1'b1;
			rec_nxt.hit_idx = MY_IDX;
		end
		if (!rec_in.free && !valid_q) begin
			rec_nxt.free     = 1'b1;
			rec_nxt.free_idx = MY_IDX;
		end
		if ($signed(score_q) < $signed(rec_in.best)) begin
			rec_nxt.best   = score_q;
			rec_nxt.victim = MY_IDX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			id_q    <= '0;
			score_q <= '0;
		end else if (cmd.tick) begin
			if (id_q != '0) begin
				if (nonpos) begin
					valid_q <= 1'b0;
					id_q    <= '0;
					score_q <= '0;
				end else begin
					score_q <= aged[SCORE_W-1:0];
				end
			end
		end else if (my_wr) begin
			valid_q <= cmd.valid_val;
			if (cmd.id_en) begin
				id_q <= cmd.id;
			end
			if (cmd.score_en) begin
				score_q <= cmd.score;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (rec_in.act) begin
			rec_q <= rec_nxt;
		end else begin
			rec_q.act <= 1'b0;
		end
	end

	assign rec_out = rec_q;

endmodule

>>> hdl/asc_ctrl.sv
// controller: config registers, item sequencing and decision on the search result
module asc_ctrl import asc_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [FRM_W-1:0]      frames,
	input  logic [ID_W-1:0]       resource_id,
	input  logic                  hit_at_limit,
	input  logic                  load_ok,
	input  logic                  load_at_limit,
	input  logic                  loading_locked,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output slot_cmd_t             cmd,
	output scan_rec_t             launch,
	input  scan_rec_t             chain_out,
	input  logic [SLOTS-1:0]      freed,
	output logic                  done,
	output logic [2:0]            status,
	output slot_idx_t             slot_index,
	output logic                  evicted_valid,
	output logic [MASK_W-1:0]     freed_mask
);

	typedef enum logic [1:0] {S_IDLE, S_TICK, S_SCAN} state_t;

	state_t              state_q;
	logic [14:0]         score_on_use_q;
	logic [SCORE_W-1:0]  scan_start_q;
	slot_cmd_t           cmd_q;
	scan_rec_t           launch_q;
	logic                hit_lim_q;
	logic                load_ok_q;
	logic                load_lim_q;
	logic                locked_q;
	logic                done_q;
	status_t             status_q;
	slot_idx_t           slot_q;
	logic                ev_q;
	logic [MASK_W-1:0]   mask_q;
	logic [MASK_W-1:0]   mask_ext;

	// decision on the finished search
	status_t             dec_status;
	slot_idx_t           dec_slot;
	logic                dec_ev;
	logic                dec_we;
	slot_idx_t           dec_idx;
	logic                dec_valid;
	logic                dec_id_en;

	logic accept;
	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		mask_ext = '0;
		mask_ext[SLOTS-1:0] = freed;
	end

	always_comb begin
		dec_status = ST_BUSY;
		dec_slot   = '0;
		dec_ev     = 1'b0;
		dec_we     = 1'b0;
		dec_idx    = '0;
		dec_valid  = 1'b1;
		dec_id_en  = 1'b0;
		if (chain_out.hit) begin
			if (!hit_lim_q) begin
				dec_status = ST_HIT;
				dec_slot   = chain_out.hit_idx;
				dec_we     = 1'b1;
				dec_idx    = chain_out.hit_idx;
			end
		end else if (chain_out.free) begin
			if (!load_ok_q) begin
				dec_status = ST_LOAD_FAIL;
			end else if (!load_lim_q) begin
				dec_status = ST_LOADED;
				dec_slot   = chain_out.free_idx;
				dec_we     = 1'b1;
				dec_idx    = chain_out.free_idx;
				dec_id_en  = 1'b1;
			end
		end else if (!locked_q) begin
			dec_status = ST_UNLOCKED;
		end else begin
			// no free slot means every slot, the victim too, is valid
			dec_ev  = 1'b1;
			dec_we  = 1'b1;
			dec_idx = chain_out.victim;
			if (load_ok_q) begin
				dec_status = ST_EVICTED;
				dec_slot   = chain_out.victim;
				dec_id_en  = 1'b1;
			end else begin
				dec_status = ST_RELOAD_FAIL;
				dec_valid  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			score_on_use_q <= 15'd1000;
			scan_start_q   <= 16'h7fff;
			cmd_q          <= '0;
			launch_q       <= '0;
			hit_lim_q      <= 1'b0;
			load_ok_q      <= 1'b0;
			load_lim_q     <= 1'b0;
			locked_q       <= 1'b0;
			done_q         <= 1'b0;
			status_q       <= ST_HIT;
			slot_q         <= '0;
			ev_q           <= 1'b0;
			mask_q         <= '0;
		end else begin
			done_q       <= (state_q == S_TICK) || ((state_q == S_SCAN) && chain_out.act);
			cmd_q.tick   <= accept && !func;
			cmd_q.we     <= (state_q == S_SCAN) && chain_out.act && dec_we;
			launch_q.act <= accept && func;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SCORE_ON_USE: score_on_use_q <= cfg_data[14:0];
					REG_SCAN_START:   scan_start_q   <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q.frames <= frames;
						cmd_q.id     <= resource_id;
						hit_lim_q    <= hit_at_limit;
						load_ok_q    <= load_ok;
						load_lim_q   <= load_at_limit;
						locked_q     <= loading_locked;
						if (!func) begin
							state_q <= S_TICK;
						end else begin
							launch_q.hit      <= 1'b0;
							launch_q.hit_idx  <= '0;
							launch_q.free     <= 1'b0;
							launch_q.free_idx <= '0;
							launch_q.best     <= scan_start_q;
							launch_q.victim   <= '0;
							state_q           <= S_SCAN;
						end
					end
				end
				S_TICK: begin
					status_q <= ST_TICK_DONE;
					slot_q   <= '0;
					ev_q     <= 1'b0;
					mask_q   <= mask_ext;
					state_q  <= S_IDLE;
				end
				S_SCAN: begin
					if (chain_out.act) begin
						status_q        <= dec_status;
						slot_q          <= dec_slot;
						ev_q            <= dec_ev;
						mask_q          <= '0;
						cmd_q.idx       <= dec_idx;
						cmd_q.valid_val <= dec_valid;
						cmd_q.id_en     <= dec_id_en;
						cmd_q.score_en  <= dec_valid;
						cmd_q.score     <= {1'b0, score_on_use_q};
						state_q         <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign cmd           = cmd_q;
	assign launch        = launch_q;
	assign done          = done_q;
	assign status        = status_q;
	assign slot_index    = slot_q;
	assign evicted_valid = ev_q;
	assign freed_mask    = mask_q;

endmodule

>>> hdl/aging_slot_cache_with_eviction_unit.sv
// top level of the aging slot cache: controller and a chain of slot cells
//
// channel   | handshake               | payload
// ----------+-------------------------+-----------------------------------------------
// item in   | start, busy             | func frames resource_id hit_at_limit load_ok
//           |                         | load_at_limit loading_locked
// result    | done (one-cycle strobe) | status slot_index evicted_valid freed_mask
// config    | cfg_we                  | cfg_index cfg_data
//
// a tick ages all cells together in the S_TICK state; done strobes as the controller leaves it
// an acquire launches the search record into the cell chain; the search record
// walks the cell chain one slot per cycle, then the controller decides and registers done
// busy drops together with the done strobe, so the next item can enter then
// reset clears every slot and loads the register defaults; the receiver cannot stall
module aging_slot_cache_with_eviction_unit import asc_pkg::*; #(
	parameter int SLOTS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic                  func,
	input  logic [FRM_W-1:0]      frames,
	input  logic [ID_W-1:0]       resource_id,
	input  logic                  hit_at_limit,
	input  logic                  load_ok,
	input  logic                  load_at_limit,
	input  logic                  loading_locked,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [2:0]            status,
	output logic [IDX_W-1:0]      slot_index,
	output logic                  evicted_valid,
	output logic [MASK_W-1:0]     freed_mask
);

`include "assert_macros.svh"

	slot_cmd_t        cmd;
	scan_rec_t        link [SLOTS+1];
	logic [SLOTS-1:0] freed;

	asc_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.frames         (frames),
		.resource_id    (resource_id),
		.hit_at_limit   (hit_at_limit),
		.load_ok        (load_ok),
		.load_at_limit  (load_at_limit),
		.loading_locked (loading_locked),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.cmd            (cmd),
		.launch         (link[0]),
		.chain_out      (link[SLOTS]),
		.freed          (freed),
		.done           (done),
		.status         (status),
		.slot_index     (slot_index),
		.evicted_valid  (evicted_valid),
		.freed_mask     (freed_mask)
	);

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		asc_cell #(.INDEX(i)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cmd     (cmd),
			.rec_in  (link[i]),
			.rec_out (link[i+1]),
			.freed   (freed[i])
		);
	end

	// the search record reaches the end of the chain only while a search runs
	`ASSERT_PROP(a_chain_in_scan, clk, arst_n, link[SLOTS].act |-> busy, "chain output outside search")
	`ASSERT_PROP(a_take_busy, clk, arst_n, (start && !busy) |=> (busy && !done), "item taken but not busy")
	`ASSERT_PROP(a_done_single, clk, arst_n, done |-> (!busy && !$past(done)), "done strobe too long")
	`ASSERT_NEVER(a_mask_acq, clk, arst_n, done && (status != ST_TICK_DONE) && (freed_mask != '0), "freed mask on acquire")

endmodule
